/* rtl/cfbr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Comb filter bank reverb package
// Shared widths, line depths, register codes and saturation helper.
// ----------------------------------------------------------------------------
package cfbr_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int GAIN_BITS   = 15;
  localparam int Q_SHIFT     = 15;
  localparam int NUM_LINES   = 4;
  localparam int POS_BITS    = 10;

  // Delay line lengths, one per comb
  localparam int LINE_DEPTH [NUM_LINES] = '{441, 353, 647, 907};

  // Datapath widths
  localparam int FB_PROD_BITS  = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int SUM_BITS      = SAMPLE_BITS + 2;
  localparam int WET_PROD_BITS = SUM_BITS + GAIN_BITS + 1;
  localparam int DRY_PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int WIDE_BITS     = WET_PROD_BITS + 2;

  // Result queue
  localparam int FIFO_DEPTH    = 8;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = GAIN_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic        [GAIN_BITS-1:0]   gain_t;
  typedef logic signed [WIDE_BITS-1:0]   wide_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_FEEDBACK = 2'd0,
    REG_WET      = 2'd1,
    REG_DRY      = 2'd2
  } cfg_reg_t;

  localparam gain_t FEEDBACK_RESET = GAIN_BITS'(22938);
  localparam gain_t WET_RESET      = GAIN_BITS'(16384);
  localparam gain_t DRY_RESET      = GAIN_BITS'(16384);

  localparam wide_t ROUND_HALF = WIDE_BITS'(2 ** (Q_SHIFT - 1));
  localparam wide_t SAMPLE_MAX = WIDE_BITS'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam wide_t SAMPLE_MIN = -SAMPLE_MAX - WIDE_BITS'(1);

  typedef struct packed {
    sample_t sample;
    logic    last;
  } result_t;

  // Clamp a wide signed value to the sample range
  function automatic sample_t sat_sample(input wide_t v);
    sample_t r;
    if (v > SAMPLE_MAX) begin
      r = SAMPLE_BITS'(SAMPLE_MAX);
    end else if (v < SAMPLE_MIN) begin
      r = SAMPLE_BITS'(SAMPLE_MIN);
    end else begin
      r = SAMPLE_BITS'(v);
    end
    return r;
  endfunction

endpackage

/* rtl/comb_filter_bank_reverb_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Comb filter bank reverb core
// Four parallel feedback comb delay lines mixed with the dry input.
// ----------------------------------------------------------------------------
// Takes one signed 16-bit sample per item and returns one mixed sample per
// item, in order, with tlast echoed. The block accepts one item every clock
// cycle while the queue has room for all items in flight; each delay line is
// a single-port-per-direction memory that is read once and written once per
// item, which sets that rate. Results collect in an eight-entry queue, so the
// input keeps flowing while a result waits. Delay lines need no clearing pass
// after reset: until a line first wraps, its unwritten entries read as zero.
// Users write gains via cfg_we/cfg_index/cfg_data only while idle; unenforced.
module comb_filter_bank_reverb_core (
  input  logic                                clk,
  input  logic                                rst,
  // Input items
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [cfbr_pkg::SAMPLE_BITS-1:0]    s_axis_tdata,   // [15:0] in_sample
  input  logic                                s_axis_tlast,   // last_in_frame
  // Result items
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [cfbr_pkg::SAMPLE_BITS-1:0]    m_axis_tdata,   // [15:0] out_sample
  output logic                                m_axis_tlast,   // frame_end
  // Configuration writes
  input  logic                                cfg_we,
  input  logic [cfbr_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [cfbr_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import cfbr_pkg::*;

  // Gain registers
  gain_t feedback_gain;
  gain_t wet_gain;
  gain_t dry_gain;

  // Line positions and fill flags
  logic [POS_BITS-1:0] line_pos [NUM_LINES];
  logic [NUM_LINES-1:0] line_wrapped;

  logic accept;

  // Stage 1: memory read data
  logic                s1_valid;
  sample_t             s1_x;
  logic                s1_last;
  logic [POS_BITS-1:0] s1_pos  [NUM_LINES];
  sample_t             s1_rd   [NUM_LINES];
  logic [NUM_LINES-1:0] s1_live;
  sample_t             s1_d    [NUM_LINES];
  logic signed [SUM_BITS-1:0]     s1_sum;
  logic signed [FB_PROD_BITS-1:0] s1_prod [NUM_LINES];

  // Stage 2: feedback products, write back
  logic                s2_valid;
  sample_t             s2_x;
  logic                s2_last;
  logic [POS_BITS-1:0] s2_pos  [NUM_LINES];
  logic signed [FB_PROD_BITS-1:0] s2_prod [NUM_LINES];
  logic signed [SUM_BITS-1:0]     s2_sum;
  sample_t             comb_val [NUM_LINES];
  logic signed [DRY_PROD_BITS-1:0] s2_pdry;
  logic signed [WET_PROD_BITS-1:0] s2_pwet;

  // Stage 3: mix products
  logic                s3_valid;
  logic                s3_last;
  logic signed [DRY_PROD_BITS-1:0] s3_pdry;
  logic signed [WET_PROD_BITS-1:0] s3_pwet;
  wide_t               mix_acc;
  sample_t             mix_val;

  // Result queue
  result_t                  fifo_mem [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] fifo_wr_ptr;
  logic [FIFO_PTR_BITS-1:0] fifo_rd_ptr;
  logic [FIFO_CNT_BITS-1:0] fifo_cnt;
  logic [FIFO_CNT_BITS-1:0] fifo_cnt_next;
  logic [FIFO_CNT_BITS-1:0] occupancy;
  logic                     fifo_push;
  logic                     fifo_pop;
  result_t                  fifo_head;

  // Write gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      feedback_gain <= FEEDBACK_RESET;
      wet_gain      <= WET_RESET;
      dry_gain      <= DRY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FEEDBACK: feedback_gain <= cfg_data;
        REG_WET:      wet_gain      <= cfg_data;
        REG_DRY:      dry_gain      <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Admit an item while the queue has room for everything in flight
  always_comb begin
    occupancy = fifo_cnt + FIFO_CNT_BITS'(s1_valid) + FIFO_CNT_BITS'(s2_valid)
              + FIFO_CNT_BITS'(s3_valid);
    s_axis_tready = (occupancy < FIFO_CNT_BITS'(FIFO_DEPTH));
    accept = s_axis_tvalid && s_axis_tready;
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Capture input item
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x    <= s_axis_tdata;
      s1_last <= s_axis_tlast;
    end
  end

  // One memory per comb line
  for (genvar g = 0; g < NUM_LINES; g++) begin : g_line
    localparam int DEPTH = LINE_DEPTH[g];
    localparam int AW    = $clog2(DEPTH);

    sample_t       mem [DEPTH];
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    wide_t         fb_round;
    wide_t         comb_sum;

    assign rd_addr = line_pos[g][AW-1:0];
    assign wr_addr = s2_pos[g][AW-1:0];

    // Advance position with wrap; mark the line filled on first wrap
    always_ff @(posedge clk) begin
      if (rst) begin
        line_pos[g]     <= '0;
        line_wrapped[g] <= 1'b0;
      end else if (accept) begin
        if (line_pos[g] == POS_BITS'(DEPTH - 1)) begin
          line_pos[g]     <= '0;
          line_wrapped[g] <= 1'b1;
        end else begin
          line_pos[g] <= line_pos[g] + POS_BITS'(1);
        end
      end
    end

    // Write back the comb value; read the oldest sample, forwarding a same-entry write
    always_ff @(posedge clk) begin
      if (s2_valid) begin
        mem[wr_addr] <= comb_val[g];
      end
      if (accept) begin
        if (s2_valid && (wr_addr == rd_addr)) begin
          s1_rd[g] <= comb_val[g];
        end else begin
          s1_rd[g] <= mem[rd_addr];
        end
        s1_live[g] <= line_wrapped[g];
        s1_pos[g]  <= line_pos[g];
      end
    end

    // Unwritten entries read as zero; scale by feedback gain
    always_comb begin
      s1_d[g]    = s1_live[g] ? s1_rd[g] : '0;
      s1_prod[g] = FB_PROD_BITS'(s1_d[g] * $signed({1'b0, feedback_gain}));
    end

    // Round, add input, saturate
    always_comb begin
      fb_round     = (WIDE_BITS'(s2_prod[g]) + ROUND_HALF) >>> Q_SHIFT;
      comb_sum     = WIDE_BITS'(s2_x) + fb_round;
      comb_val[g]  = sat_sample(comb_sum);
    end
  end

  // Sum the four delayed samples
  always_comb begin
    s1_sum = SUM_BITS'(s1_d[0]) + SUM_BITS'(s1_d[1]) + SUM_BITS'(s1_d[2])
           + SUM_BITS'(s1_d[3]);
  end

  // Register feedback products
  always_ff @(posedge clk) begin
    s2_x    <= s1_x;
    s2_last <= s1_last;
    s2_sum  <= s1_sum;
    s2_prod <= s1_prod;
    s2_pos  <= s1_pos;
  end

  // Mix products
  always_comb begin
    s2_pdry = DRY_PROD_BITS'(s2_x * $signed({1'b0, dry_gain}));
    s2_pwet = WET_PROD_BITS'(s2_sum * $signed({1'b0, wet_gain}));
  end

  always_ff @(posedge clk) begin
    s3_last <= s2_last;
    s3_pdry <= s2_pdry;
    s3_pwet <= s2_pwet;
  end

  // Add, round and saturate the mix
  always_comb begin
    mix_acc = (WIDE_BITS'(s3_pdry) + WIDE_BITS'(s3_pwet) + ROUND_HALF) >>> Q_SHIFT;
    mix_val = sat_sample(mix_acc);
  end

  // Queue results
  assign fifo_push = s3_valid;
  assign fifo_pop  = m_axis_tvalid && m_axis_tready;

  always_comb begin
    fifo_cnt_next = fifo_cnt + FIFO_CNT_BITS'(fifo_push) - FIFO_CNT_BITS'(fifo_pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fifo_wr_ptr <= '0;
      fifo_rd_ptr <= '0;
      fifo_cnt    <= '0;
    end else begin
      if (fifo_push) begin
        fifo_wr_ptr <= fifo_wr_ptr + FIFO_PTR_BITS'(1);
      end
      if (fifo_pop) begin
        fifo_rd_ptr <= fifo_rd_ptr + FIFO_PTR_BITS'(1);
      end
      fifo_cnt <= fifo_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_push) begin
      fifo_mem[fifo_wr_ptr] <= '{sample: mix_val, last: s3_last};
    end
  end

  assign fifo_head     = fifo_mem[fifo_rd_ptr];
  assign m_axis_tvalid = (fifo_cnt != '0);
  assign m_axis_tdata  = fifo_head.sample;
  assign m_axis_tlast  = fifo_head.last;

  // Queue plus in-flight items never exceed queue capacity
  assert property (@(posedge clk) disable iff (rst)
    occupancy <= FIFO_CNT_BITS'(FIFO_DEPTH))
    else $error("result queue overcommitted");

  // Line 0 becomes filled only as its position wraps to zero
  assert property (@(posedge clk) disable iff (rst)
    $rose(line_wrapped[0]) |-> (line_pos[0] == '0))
    else $error("line fill flag set off wrap");

  // Every push into the queue comes from an item two stages earlier
  assert property (@(posedge clk) disable iff (rst)
    s3_valid |-> $past(s1_valid, 2))
    else $error("pipeline produced an item from nothing");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Comb filter bank reverb core testbench
// Drives signed samples with frame marks through the stream input while the
// result side stalls at random. A behavioral model of the four feedback combs
// and the dry/wet mix predicts each output sample. Every result is checked in
// order against that prediction. Gain settings are changed between phases
// while the core is idle, and include the extremes and an unused register
// index.
// ----------------------------------------------------------------------------
module tb;
  import cfbr_pkg::*;

  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 2'd3;
  localparam int     IDLE_PCT       = 21;
  localparam int     HOLD_CYCLES    = 64;
  localparam int     SETTLE_CYCLES  = 8;    // pipeline plus margin
  localparam int     WATCHDOG_LIMIT = 2000;
  localparam int     MAX_REPORTS    = 10;
  localparam int     RAND_PHASES    = 9;
  localparam int     PHASE_ITEMS    = 190;
  localparam longint ROUND_Q        = longint'(1) <<< (Q_SHIFT - 1);
  localparam longint CLIP_HI        = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint CLIP_LO        = -CLIP_HI - 1;

  logic                     clk           = 1'b0;
  logic                     rst           = 1'b1;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [SAMPLE_BITS-1:0]   s_axis_tdata  = '0;   // [15:0] in_sample
  logic                     s_axis_tlast  = 1'b0; // last_in_frame
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [SAMPLE_BITS-1:0]   m_axis_tdata;         // [15:0] out_sample
  logic                     m_axis_tlast;         // frame_end
  logic                     cfg_we        = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index     = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data      = '0;

  // Comb model state and gains
  sample_t echo_mem [NUM_LINES][1024];
  int      echo_pos [NUM_LINES];
  gain_t   fb_gain;
  gain_t   wet_gain;
  gain_t   dry_gain;

  result_t expected_mix [$];

  bit src_idle_on = 1'b1;
  bit rx_idle_on  = 1'b1;
  bit hold_req    = 1'b0;
  bit hold_ack    = 1'b0;
  int hold_left   = 0;
  int idle_cycles = 0;

  int mismatch_count = 0;
  int items_sent     = 0;
  int results_seen   = 0;
  int cfg_writes     = 0;
  int holds_done     = 0;

  comb_filter_bank_reverb_core dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  // Clamp to the signed sample range
  function automatic sample_t clip_sample(input longint v);
    if (v > CLIP_HI) begin
      return sample_t'(CLIP_HI);
    end else if (v < CLIP_LO) begin
      return sample_t'(CLIP_LO);
    end
    return sample_t'(v);
  endfunction

  // Clear the lines and restore the reset gains
  function automatic void clear_combs();
    for (int k = 0; k < NUM_LINES; k++) begin
      for (int j = 0; j < 1024; j++) begin
        echo_mem[k][j] = '0;
      end
      echo_pos[k] = 0;
    end
    fb_gain  = FEEDBACK_RESET;
    wet_gain = WET_RESET;
    dry_gain = DRY_RESET;
  endfunction

  // Run one sample through the four combs and mix it with the dry path
  function automatic result_t mix_next(input sample_t smp, input logic lst);
    longint  x;
    longint  d;
    longint  sum;
    longint  acc;
    result_t r;
    x   = smp;
    sum = 0;
    for (int k = 0; k < NUM_LINES; k++) begin
      d = echo_mem[k][echo_pos[k]];
      echo_mem[k][echo_pos[k]] =
        clip_sample(x + ((d * longint'(fb_gain) + ROUND_Q) >>> Q_SHIFT));
      sum += d;
      echo_pos[k] = (echo_pos[k] + 1 >= LINE_DEPTH[k]) ? 0 : echo_pos[k] + 1;
    end
    acc      = x * longint'(dry_gain) + sum * longint'(wet_gain) + ROUND_Q;
    r.sample = clip_sample(acc >>> Q_SHIFT);
    r.last   = lst;
    return r;
  endfunction

  // Mix of full-scale, quiet and arbitrary levels
  function automatic sample_t pick_level();
    case ($urandom_range(9))
      0:       return sample_t'(CLIP_HI);
      1:       return sample_t'(CLIP_LO);
      2:       return sample_t'(int'($urandom_range(512)) - 256);
      default: return sample_t'($urandom());
    endcase
  endfunction

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
    end
  endtask

  // Offer one item, hold it until accepted, then predict its result
  task automatic send_item(input sample_t smp, input logic lst);
    if (src_idle_on) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= smp;
    s_axis_tlast  <= lst;
    do @(posedge clk); while (!s_axis_tready);
    expected_mix.push_back(mix_next(smp, lst));
    items_sent++;
  endtask

  // Stop offering and wait for every pending result
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_mix.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_gain(input logic [CFG_IDX_BITS-1:0] idx, input gain_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      REG_FEEDBACK: fb_gain  = val;
      REG_WET:      wet_gain = val;
      REG_DRY:      dry_gain = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  task automatic set_gains(input gain_t fb, input gain_t wet, input gain_t dry);
    drain_results();
    write_gain(REG_FEEDBACK, fb);
    write_gain(REG_WET, wet);
    write_gain(REG_DRY, dry);
  endtask

  // Frames of one to eight channels, with some stray frame marks
  task automatic send_frames(input int n);
    int   left;
    int   chans;
    logic lst;
    left = n;
    while (left > 0) begin
      chans = $urandom_range(8, 1);
      for (int c = 0; c < chans && left > 0; c++) begin
        lst = (c == chans - 1);
        if ($urandom_range(9) == 0) begin
          lst = 1'($urandom_range(1));
        end
        send_item(pick_level(), lst);
        left--;
      end
    end
  endtask

  // Extremes and bit patterns at the reset gains
  task automatic test_reset_gains();
    send_item(sample_t'(CLIP_HI), 1'b0);
    send_item(sample_t'(CLIP_LO), 1'b1);
    send_item(16'sd0, 1'b0);
    send_item(16'sd1, 1'b0);
    send_item(-16'sd1, 1'b1);
    send_item(16'h5555, 1'b0);
    send_item(16'hAAAA, 1'b1);
    send_item(sample_t'(CLIP_HI), 1'b0);
    send_item(sample_t'(CLIP_HI), 1'b0);
    send_item(sample_t'(CLIP_LO), 1'b1);
  endtask

  // Gain extremes, plus a write to the unused index that must change nothing
  task automatic test_gain_writes();
    set_gains(15'h7FFF, 15'h7FFF, 15'h7FFF);
    write_gain(REG_UNUSED, 15'h0000);
    repeat (3) send_item(sample_t'(CLIP_HI), 1'b0);
    repeat (3) send_item(sample_t'(CLIP_LO), 1'b1);
    set_gains(15'h0000, 15'h0000, 15'h0000);
    send_item(sample_t'(CLIP_HI), 1'b1);
    send_item(sample_t'(CLIP_LO), 1'b0);
    set_gains(15'h0000, 15'h0000, 15'h7FFF);
    send_item(sample_t'(CLIP_HI), 1'b0);
    send_item(sample_t'(CLIP_LO), 1'b0);
    send_item(16'sd1, 1'b1);
  endtask

  // Hold off the result side while items keep coming, so the input stalls
  task automatic test_backpressure();
    set_gains(FEEDBACK_RESET, WET_RESET, DRY_RESET);
    src_idle_on = 1'b0;
    hold_req   <= ~hold_req;
    send_frames(48);
    src_idle_on = 1'b1;
  endtask

  // Long stretch with both sides always ready
  task automatic test_steady_stream();
    drain_results();
    src_idle_on = 1'b0;
    rx_idle_on  = 1'b0;
    send_frames(300);
    src_idle_on = 1'b1;
    rx_idle_on  = 1'b1;
  endtask

  // Random frames under a sweep of gain settings
  task automatic test_random_settings();
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph)
        0:       set_gains(FEEDBACK_RESET, WET_RESET, DRY_RESET);
        1:       set_gains(15'h7FFF, 15'h7FFF, 15'h7FFF);
        2:       set_gains(15'h0000, 15'h0000, 15'h0000);
        3:       set_gains(15'h7FFF, 15'h7FFF, 15'h0000);
        4:       set_gains(15'h0000, 15'h7FFF, 15'h7FFF);
        5:       set_gains(15'h7FFF, 15'h0000, 15'h7FFF);
        default: set_gains(gain_t'($urandom()), gain_t'($urandom()), gain_t'($urandom()));
      endcase
      send_frames(PHASE_ITEMS);
    end
  endtask

  // Result side readiness: random stalls and the requested hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack      <= hold_req;
      hold_left     <= HOLD_CYCLES;
      m_axis_tready <= 1'b0;
      holds_done++;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(rx_idle_on && ($urandom_range(99) < IDLE_PCT));
    end
  end

  // Compare each result with the oldest prediction
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (expected_mix.size() == 0) begin
        flag_mismatch("unexpected result", 0, $signed(m_axis_tdata));
      end else begin
        want = expected_mix.pop_front();
        if (m_axis_tdata !== want.sample) begin
          flag_mismatch("out_sample", want.sample, $signed(m_axis_tdata));
        end
        if (m_axis_tlast !== want.last) begin
          flag_mismatch("frame_end", want.last, m_axis_tlast);
        end
      end
    end
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout after %0d cycles without progress", idle_cycles);
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    clear_combs();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_gains();
    test_gain_writes();
    test_backpressure();
    test_steady_stream();
    test_random_settings();
    drain_results();
    $display("Sent %0d samples, checked %0d results, %0d gain writes, %0d hold-offs.",
             items_sent, results_seen, cfg_writes, holds_done);
    $display("Gains swept through zero, reset and full scale with full-scale and random input.");
    if (mismatch_count == 0 && expected_mix.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/cfbr_pkg.sv
rtl/comb_filter_bank_reverb_core.sv
tb/sv/tb.sv
